// ===== rtl/core/fapa_pkg.sv =====
package fapa_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);

  localparam logic [1:0] CfgReuseAge   = 2'd0;
  localparam logic [1:0] CfgReleaseAge = 2'd1;
  localparam logic [1:0] CfgMinPage    = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [9:0]  usage;
    logic [4:0]  lg;
    logic [31:0] bump;
    logic [31:0] last_frame;
  } page_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUMP,
    ST_REUSE,
    ST_INSERT,
    ST_SHIFT,
    ST_REL,
    ST_RELSHIFT,
    ST_CLOSE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        st;
    logic [15:0] id;
    logic [31:0] off;
    logic [4:0]  lg;
    logic        cr;
    logic        rel;
    logic        last;
  } result_t;

  // page fit/age compare results
  typedef struct packed {
    logic bump_ok;
    logic reuse_ok;
    logic release_ok;
  } match_t;

endpackage

// ===== rtl/core/frame_aged_upload_page_allocator.sv =====
// allocate: an oversized request goes straight to its result; else a bump scan,
//   a reuse scan if that misses, then an insert at entry 0 unless the table is full
// begin-frame: scan down from the last entry, closing up each release, then close
// throughput: one item at a time, busy drops as its last result is presented
// reset: synchronous active-low rst_n clears valid bits, frame, id, registers
// results show for one cycle on out_valid; the receiver cannot stall
module frame_aged_upload_page_allocator
  import fapa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_request_bytes,
  input  logic [9:0]  in_usage_class,
  input  logic [16:0] in_align_bytes,
  input  logic [31:0] in_frame_number,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic        out_status,
  output logic [15:0] out_buffer_id,
  output logic [31:0] out_offset,
  output logic [4:0]  out_page_log2,
  output logic        out_created,
  output logic        out_released,
  output logic        out_last
);
  page_t                 tbl_r [TableDepth];
  logic [TableDepth-1:0] vld_r;
  state_t state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt, sh_r, sh_nxt;
  logic [31:0] bytes_r, frame_r, cur_r;
  logic [9:0]  usage_r;
  logic [16:0] align_r;
  logic [15:0] nid_r, rel_age_r;
  logic [7:0]  reuse_age_r;
  logic [4:0]  minlg_r;
  logic        out_v_r;
  result_t     res_r;
  page_t       pg;
  logic [31:0] al;
  match_t      m;
  logic [4:0]  clg;

  assign pg = tbl_r[idx_r];
  fapa_match u_match (
    .page(pg), .req_bytes(bytes_r), .req_usage(usage_r), .req_align(align_r),
    .cur_frame(cur_r), .new_frame(frame_r), .reuse_age(reuse_age_r),
    .release_age(rel_age_r), .aligned_off(al), .m(m)
  );

  // ceil log2 of request, capped at 31
  always_comb begin
    clg = 5'd31;
    for (int k = 30; k >= 0; k--) begin
      if ({1'b0, bytes_r} <= (33'd1 << k)) clg = 5'(k);
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sh_nxt    = sh_r;
    unique case (state_r)
      ST_IDLE: ;
      ST_BUMP: begin
        if (vld_r[idx_r] && m.bump_ok) state_nxt = ST_DONE;
        else if (idx_r == IdxW'(TableDepth - 1)) begin
          state_nxt = ST_REUSE;
          idx_nxt   = '0;
        end else idx_nxt = idx_r + 1'b1;
      end
      ST_REUSE: begin
        if (vld_r[idx_r] && m.reuse_ok) state_nxt = ST_DONE;
        else if (idx_r == IdxW'(TableDepth - 1)) state_nxt = ST_INSERT;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_INSERT: begin
        if (vld_r[TableDepth-1]) state_nxt = ST_DONE;
        else begin
          state_nxt = ST_SHIFT;
          sh_nxt    = IdxW'(TableDepth - 1);
        end
      end
      ST_SHIFT: begin
        if (sh_r == '0) state_nxt = ST_DONE;
        else sh_nxt = sh_r - 1'b1;
      end
      ST_REL: begin
        if (vld_r[idx_r] && m.release_ok) begin
          state_nxt = ST_RELSHIFT;
          sh_nxt    = idx_r;
        end else if (idx_r == '0) state_nxt = ST_CLOSE;
        else idx_nxt = idx_r - 1'b1;
      end
      ST_RELSHIFT: begin
        if (sh_r == IdxW'(TableDepth - 1)) begin
          if (idx_r == '0) state_nxt = ST_CLOSE;
          else begin
            state_nxt = ST_REL;
            idx_nxt   = idx_r - 1'b1;
          end
        end else sh_nxt = sh_r + 1'b1;
      end
      ST_CLOSE: state_nxt = ST_IDLE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE && start) begin
      if (in_action) begin
        state_nxt = ST_REL;
        idx_nxt   = IdxW'(TableDepth - 1);
      end else if ({1'b0, in_request_bytes} > 33'h080000000) state_nxt = ST_DONE;
      else begin
        state_nxt = ST_BUMP;
        idx_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      cur_r       <= '0;
      nid_r       <= '0;
      reuse_age_r <= 8'd3;
      rel_age_r   <= 16'd100;
      minlg_r     <= 5'd14;
      out_v_r     <= 1'b0;
      idx_r       <= '0;
      sh_r        <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      sh_r    <= sh_nxt;
      // result strobe: done, close, or a released page
      out_v_r <= (state_r == ST_DONE) || (state_r == ST_CLOSE) ||
                 ((state_r == ST_REL) && vld_r[idx_r] && m.release_ok);
      // config writes
      if (cfg_we) begin
        unique case (cfg_index)
          CfgReuseAge:   reuse_age_r <= cfg_data[7:0];
          CfgReleaseAge: rel_age_r   <= cfg_data;
          CfgMinPage:    minlg_r     <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && start) begin
        bytes_r <= in_request_bytes;
        usage_r <= in_usage_class;
        align_r <= in_align_bytes;
        frame_r <= in_frame_number;
        res_r   <= '{st: 1'b1, id: 16'd0, off: 32'd0, lg: 5'd0, cr: 1'b0,
                     rel: 1'b0, last: 1'b1};
      end
      unique case (state_r)
        ST_BUMP: if (vld_r[idx_r] && m.bump_ok) begin
          tbl_r[idx_r].bump <= al + bytes_r;
          res_r <= '{st: 1'b0, id: pg.id, off: al, lg: pg.lg, cr: 1'b0,
                     rel: 1'b0, last: 1'b1};
        end
        ST_REUSE: if (vld_r[idx_r] && m.reuse_ok) begin
          tbl_r[idx_r].bump       <= bytes_r;
          tbl_r[idx_r].last_frame <= cur_r;
          res_r <= '{st: 1'b0, id: pg.id, off: 32'd0, lg: pg.lg, cr: 1'b0,
                     rel: 1'b0, last: 1'b1};
        end
        ST_SHIFT: begin
          if (sh_r == '0) begin
            tbl_r[0] <= '{id: nid_r, usage: usage_r,
                          lg: (clg < minlg_r) ? minlg_r : clg,
                          bump: bytes_r, last_frame: cur_r};
            vld_r[0] <= 1'b1;
            nid_r    <= nid_r + 16'd1;
            res_r <= '{st: 1'b0, id: nid_r, off: 32'd0,
                       lg: (clg < minlg_r) ? minlg_r : clg, cr: 1'b1,
                       rel: 1'b0, last: 1'b1};
          end else begin
            tbl_r[sh_r] <= tbl_r[sh_r - 1'b1];
            vld_r[sh_r] <= vld_r[sh_r - 1'b1];
          end
        end
        ST_REL: if (vld_r[idx_r] && m.release_ok) begin
          res_r <= '{st: 1'b0, id: pg.id, off: 32'd0, lg: pg.lg, cr: 1'b0,
                     rel: 1'b1, last: 1'b0};
        end
        ST_RELSHIFT: begin
          if (sh_r == IdxW'(TableDepth - 1)) vld_r[sh_r] <= 1'b0;
          else begin
            tbl_r[sh_r] <= tbl_r[sh_r + 1'b1];
            vld_r[sh_r] <= vld_r[sh_r + 1'b1];
          end
        end
        ST_CLOSE: begin
          cur_r   <= frame_r;
          res_r <= '{st: 1'b0, id: 16'd0, off: 32'd0, lg: 5'd0, cr: 1'b0,
                     rel: 1'b0, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_v_r;
  assign out_status    = res_r.st;
  assign out_buffer_id = res_r.id;
  assign out_offset    = res_r.off;
  assign out_page_log2 = res_r.lg;
  assign out_created   = res_r.cr;
  assign out_released  = res_r.rel;
  assign out_last      = res_r.last;
endmodule

// ===== rtl/core/fapa_match.sv =====
module fapa_match
  import fapa_pkg::*;
(
  input  page_t       page,
  input  logic [31:0] req_bytes,
  input  logic [9:0]  req_usage,
  input  logic [16:0] req_align,
  input  logic [31:0] cur_frame,
  input  logic [31:0] new_frame,
  input  logic [7:0]  reuse_age,
  input  logic [15:0] release_age,
  output logic [31:0] aligned_off,
  output match_t      m
);
  logic [32:0] amask;
  logic [32:0] al;
  logic [33:0] endp;
  logic [32:0] psz;
  logic [31:0] limit;
  logic [31:0] idle;

  // shared fit / age compare unit
  always_comb begin
    amask = (req_align == 17'd0) ? 33'd0 : {16'd0, req_align} - 33'd1;
    al    = ({1'b0, page.bump} + amask) & ~amask;
    endp  = {1'b0, al} + {2'd0, req_bytes};
    psz   = 33'd1 << page.lg;
    limit = cur_frame - {24'd0, reuse_age};
    idle  = new_frame - page.last_frame;
    aligned_off = al[31:0];
    m.bump_ok = (page.last_frame == cur_frame) && (page.usage == req_usage)
                && (endp <= {1'b0, psz});
    m.reuse_ok = (cur_frame >= {24'd0, reuse_age}) && (page.last_frame < limit)
                 && (page.usage == req_usage) && ({1'b0, req_bytes} <= psz);
    m.release_ok = idle > {16'd0, release_age};
  end
endmodule

// ===== tb/frame_aged_upload_page_allocator_test.sv =====
`timescale 1ns / 1ps

module frame_aged_upload_page_allocator_test;
  import fapa_pkg::*;

  typedef struct {
    logic        action;
    logic [31:0] bytes;
    logic [9:0]  usage;
    logic [16:0] align;
    logic [31:0] frame;
  } item_t;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFrame = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [31:0] in_request_bytes = '0;
  logic [9:0]  in_usage_class = '0;
  logic [16:0] in_align_bytes = 17'd1;
  logic [31:0] in_frame_number = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid, out_status, out_created, out_released, out_last;
  logic [15:0] out_buffer_id;
  logic [31:0] out_offset;
  logic [4:0]  out_page_log2;

  frame_aged_upload_page_allocator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // page table mirror
  logic        pg_valid [TableDepth];
  logic [15:0] pg_id    [TableDepth];
  logic [9:0]  pg_usage [TableDepth];
  logic [4:0]  pg_lg    [TableDepth];
  logic [31:0] pg_bump  [TableDepth];
  logic [31:0] pg_frame [TableDepth];
  logic [31:0] cur_frame;
  logic [15:0] next_id;
  logic [7:0]  reuse_age;
  logic [15:0] release_age;
  logic [4:0]  min_lg;

  result_t     results_due[$];
  item_t       pending[$];
  int          accepted = 0;
  int          popped = 0;
  int          idle_pct = 29;
  int          errors = 0;
  logic [31:0] gen_frame = 0;

  function automatic result_t mk(logic st, logic [15:0] id, logic [31:0] off, logic [4:0] lg,
                                 logic cr, logic rel, logic last);
    result_t r;
    r.st = st; r.id = id; r.off = off; r.lg = lg; r.cr = cr; r.rel = rel; r.last = last;
    return r;
  endfunction

  // bump, then reuse, then insert at the front
  task automatic predict_alloc(logic [31:0] size, logic [9:0] usage, logic [16:0] align);
    logic [63:0] a, al, psz;
    logic [4:0]  lg;
    int          k;
    a = (align == 0) ? 64'd1 : {47'd0, align};
    if (size > 32'h8000_0000) begin
      results_due.push_back(mk(1, 0, 0, 0, 0, 0, 1));
      return;
    end
    for (int i = 0; i < TableDepth; i++) begin
      al = ({32'd0, pg_bump[i]} + a - 1) & ~(a - 1);
      psz = 64'd1 << pg_lg[i];
      if (pg_valid[i] && pg_frame[i] == cur_frame && pg_usage[i] == usage &&
          al + size <= psz) begin
        pg_bump[i] = al[31:0] + size;
        results_due.push_back(mk(0, pg_id[i], al[31:0], pg_lg[i], 0, 0, 1));
        return;
      end
    end
    if (cur_frame >= reuse_age) begin
      for (int i = 0; i < TableDepth; i++) begin
        if (pg_valid[i] && pg_frame[i] < cur_frame - reuse_age && pg_usage[i] == usage &&
            {32'd0, size} <= (64'd1 << pg_lg[i])) begin
          pg_bump[i] = size;
          pg_frame[i] = cur_frame;
          results_due.push_back(mk(0, pg_id[i], 0, pg_lg[i], 0, 0, 1));
          return;
        end
      end
    end
    if (pg_valid[TableDepth-1]) begin
      results_due.push_back(mk(1, 0, 0, 0, 0, 0, 1));
      return;
    end
    for (int i = TableDepth - 1; i > 0; i--) begin
      pg_valid[i] = pg_valid[i-1]; pg_id[i] = pg_id[i-1]; pg_usage[i] = pg_usage[i-1];
      pg_lg[i] = pg_lg[i-1]; pg_bump[i] = pg_bump[i-1]; pg_frame[i] = pg_frame[i-1];
    end
    k = 0;
    while (k < 31 && (64'd1 << k) < {32'd0, size}) k++;
    lg = (k < min_lg) ? min_lg : k[4:0];
    pg_valid[0] = 1; pg_id[0] = next_id; pg_usage[0] = usage;
    pg_lg[0] = lg; pg_bump[0] = size; pg_frame[0] = cur_frame;
    results_due.push_back(mk(0, next_id, 0, lg, 1, 0, 1));
    next_id = next_id + 16'd1;
  endtask

  // release idle pages oldest first, then the closing item
  task automatic predict_frame(logic [31:0] frame);
    logic [31:0] idle;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      idle = frame - pg_frame[i];
      if (pg_valid[i] && idle > {16'd0, release_age}) begin
        results_due.push_back(mk(0, pg_id[i], 0, pg_lg[i], 0, 1, 0));
        for (int j = i; j < TableDepth - 1; j++) begin
          pg_valid[j] = pg_valid[j+1]; pg_id[j] = pg_id[j+1]; pg_usage[j] = pg_usage[j+1];
          pg_lg[j] = pg_lg[j+1]; pg_bump[j] = pg_bump[j+1]; pg_frame[j] = pg_frame[j+1];
        end
        pg_valid[TableDepth-1] = 0;
      end
    end
    cur_frame = frame;
    results_due.push_back(mk(0, 0, 0, 0, 0, 0, 1));
  endtask

  // driver: hold an item until taken
  always @(negedge clk) begin
    logic go;
    go = start;
    if (start && accepted != popped) begin
      popped++;
      void'(pending.pop_front());
      go = 0;
    end
    if (rst_n && !go && pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_action <= pending[0].action;
      in_request_bytes <= pending[0].bytes;
      in_usage_class <= pending[0].usage;
      in_align_bytes <= pending[0].align;
      in_frame_number <= pending[0].frame;
      go = 1;
    end
    start <= go;
  end

  // monitor: check results, then predict for a taken item
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_valid) begin
        got = mk(out_status, out_buffer_id, out_offset, out_page_log2, out_created,
                 out_released, out_last);
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = results_due.pop_front();
          if (got.st !== want.st || got.id !== want.id || got.off !== want.off ||
              got.lg !== want.lg || got.cr !== want.cr || got.rel !== want.rel ||
              got.last !== want.last) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (start && !busy) begin
        accepted++;
        if (in_action == ActFrame) predict_frame(in_frame_number);
        else predict_alloc(in_request_bytes, in_usage_class, in_align_bytes);
      end
    end
  end

  function automatic item_t alloc_item(logic [31:0] b, logic [9:0] u, logic [16:0] a);
    item_t it;
    it.action = ActAlloc; it.bytes = b; it.usage = u; it.align = a; it.frame = $urandom;
    return it;
  endfunction

  function automatic item_t frame_item(logic [31:0] f);
    item_t it;
    it.action = ActFrame; it.bytes = $urandom; it.usage = 10'($urandom);
    it.align = 17'($urandom);
    it.frame = f;
    return it;
  endfunction

  task automatic add_random(int n);
    int          r;
    logic [31:0] b;
    logic [9:0]  u;
    logic [16:0] a;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 20) begin
        r = $urandom_range(99);
        if (r < 5) gen_frame = gen_frame + $urandom_range(100, 70000);
        else if (r < 8) gen_frame = $urandom;
        else gen_frame = gen_frame + $urandom_range(1, 4);
        pending.push_back(frame_item(gen_frame));
      end else begin
        r = $urandom_range(99);
        if (r < 60) b = $urandom_range(0, 4096);
        else if (r < 80) b = $urandom_range(0, 1 << 20);
        else if (r < 88) b = $urandom_range(0, 32'h7fff_ffff);
        else if (r < 93) b = 32'h8000_0000;
        else b = $urandom;
        u = ($urandom_range(99) < 70) ? 10'($urandom_range(0, 3)) : 10'($urandom);
        r = $urandom_range(99);
        if (r < 85) a = 17'd1 << $urandom_range(0, 16);
        else if (r < 92) a = 0;
        else a = 17'($urandom);
        pending.push_back(alloc_item(b, u, a));
      end
    end
  endtask

  // register write once everything has drained
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait (pending.size() == 0);
    @(negedge clk);
    while (start || busy || results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      CfgReuseAge:   reuse_age = val[7:0];
      CfgReleaseAge: release_age = val;
      CfgMinPage:    min_lg = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      pg_valid[i] = 0; pg_id[i] = 0; pg_usage[i] = 0; pg_lg[i] = 0;
      pg_bump[i] = 0; pg_frame[i] = 0;
    end
    cur_frame = 0; next_id = 0; reuse_age = 3; release_age = 100; min_lg = 14;
    repeat (8) @(negedge clk);
    rst_n <= 1;

    // directed: young frames, field extremes, odd alignments, bump, reuse, release, wrap
    pending.push_back(frame_item(1));
    pending.push_back(alloc_item(0, 0, 1));
    pending.push_back(alloc_item(100, 0, 0));
    pending.push_back(alloc_item(10, 0, 17'd3));
    pending.push_back(alloc_item(20, 0, 17'h1ffff));
    pending.push_back(alloc_item(32'h8000_0000, 10'h3ff, 17'h10000));
    pending.push_back(alloc_item(32'h8000_0001, 10'h3ff, 1));
    pending.push_back(alloc_item(32'hffff_ffff, 10'h155, 1));
    pending.push_back(alloc_item(16384, 1, 16));
    pending.push_back(alloc_item(1, 1, 1));
    pending.push_back(frame_item(6));
    pending.push_back(alloc_item(500, 0, 64));
    pending.push_back(alloc_item(500, 0, 64));
    pending.push_back(alloc_item(300, 10'h2aa, 2));
    pending.push_back(frame_item(200));
    pending.push_back(alloc_item(8, 5, 8));
    pending.push_back(frame_item(32'hffff_ffff));
    pending.push_back(alloc_item(8, 5, 8));
    pending.push_back(frame_item(0));
    pending.push_back(alloc_item(8, 5, 8));
    gen_frame = 0;
    add_random(100);

    write_reg(CfgReuseAge, 0);
    write_reg(CfgReleaseAge, 16'hffff);
    write_reg(CfgMinPage, 31);
    idle_pct = 80;
    add_random(95);

    write_reg(CfgReuseAge, 255);
    write_reg(CfgReleaseAge, 0);
    write_reg(CfgMinPage, 0);
    idle_pct = 0;
    add_random(50);

    write_reg(CfgReuseAge, 1);
    write_reg(CfgReleaseAge, 7);
    write_reg(CfgMinPage, 10);
    add_random(50);

    wait (pending.size() == 0);
    @(negedge clk);
    while (start || busy || results_due.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("frame_aged_upload_page_allocator_test: done, clean");
    end else begin
      $display("frame_aged_upload_page_allocator_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("frame_aged_upload_page_allocator_test: done, errors");
    $finish;
  end

endmodule
